/* rtl/closest_point_on_segment_core_assert.svh */
// Assertion macros for the closest point on segment core.
// Depends on nothing; the including module provides clk and arst_n.
`ifndef CLOSEST_POINT_ON_SEGMENT_CORE_ASSERT_SVH
`define CLOSEST_POINT_ON_SEGMENT_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CPOS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cpos assertion failed");

// Next-cycle implication, checked outside reset.
`define CPOS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cpos assertion failed");

`endif

/* rtl/cpos_pkg.sv */
// Shared types and codes for the closest point on segment core.
// Depends on nothing; used by the division cell and the top level.
package cpos_pkg;

	// Which clamp applied to a result word.
	typedef enum logic [1:0] {
		WC_INTERIOR = 2'd0,
		WC_START    = 2'd1,
		WC_END      = 2'd2
	} case_t;

	localparam int unsigned AXES = 3;

endpackage

/* rtl/cpos_div_cell.sv */
// One restoring division step for all three axes, with a registered hand-on.
// Depends on cpos_pkg; chained by closest_point_on_segment_core.
module cpos_div_cell #(
	parameter int unsigned DW    = 67,
	parameter int unsigned QB    = 34,
	parameter int unsigned PASSW = 197
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    en,
	input  logic                                    in_vld,
	input  logic [cpos_pkg::AXES-1:0][DW-1:0]       in_rem,
	input  logic [cpos_pkg::AXES-1:0][QB-1:0]       in_sh,
	input  logic [DW-1:0]                           in_den,
	input  logic [PASSW-1:0]                        in_pass,
	output logic                                    out_vld,
	output logic [cpos_pkg::AXES-1:0][DW-1:0]       out_rem,
	output logic [cpos_pkg::AXES-1:0][QB-1:0]       out_sh,
	output logic [DW-1:0]                           out_den,
	output logic [PASSW-1:0]                        out_pass
);

	logic [cpos_pkg::AXES-1:0][DW-1:0] rem_nxt;
	logic [cpos_pkg::AXES-1:0][QB-1:0] sh_nxt;

	// Shift the next numerator bit into the remainder and subtract where it fits.
	always_comb begin
		logic [DW:0] trial;
		for (int i = 0; i < int'(cpos_pkg::AXES); i++) begin
			trial = {in_rem[i], in_sh[i][QB-1]};
			if (trial >= {1'b0, in_den}) begin
				rem_nxt[i] = DW'(trial - {1'b0, in_den});
				sh_nxt[i]  = {in_sh[i][QB-2:0], 1'b1};
			end else begin
				rem_nxt[i] = trial[DW-1:0];
				sh_nxt[i]  = {in_sh[i][QB-2:0], 1'b0};
			end
		end
	end

	// Valid bit of the cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= in_vld;
		end
	end

	// Payload of the cell.
	always_ff @(posedge clk) begin
		if (en) begin
			out_rem  <= rem_nxt;
			out_sh   <= sh_nxt;
			out_den  <= in_den;
			out_pass <= in_pass;
		end
	end

endmodule

/* rtl/closest_point_on_segment_core.sv */
// Closest point on a 3D segment: closest_point_on_segment_core.
// Input word: start A, end B, query P, all signed fixed point of COORD_WIDTH bits.
// Output word: the nearest point on segment AB and which_case (interior, start or end).
// Both channels use valid/ready; a word moves when valid and ready are high together.
// The block takes one word every cycle unless the receiver stalls it. It has
// five arithmetic stages, one cell per quotient bit of the restoring divider
// chain (COORD_WIDTH + 2 cells) and the output register.
// The divider chain sets the latency; each cell holds one quotient step of one word.
// The whole pipeline advances together; when the receiver holds out_ready low with
// a word waiting, every stage freezes and in_ready drops, so no word is lost.
// Reset clears all valid bits; the block is empty and ready straight after it.
// FRAC_BITS cancels in the projection ratio and does not change any result.
// Only the interior case uses the quotient; clamped words pass A or B unchanged.
// Interior coordinates round the offset from A to nearest, halves away from A, and saturate.
// The block holds no state between words.
// A degenerate segment (A equal to B) returns A, flagged as the start case.
module closest_point_on_segment_core #(
	parameter int unsigned COORD_WIDTH = 32,
	parameter int unsigned FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] start_x,
	input  logic signed [COORD_WIDTH-1:0] start_y,
	input  logic signed [COORD_WIDTH-1:0] start_z,
	input  logic signed [COORD_WIDTH-1:0] end_x,
	input  logic signed [COORD_WIDTH-1:0] end_y,
	input  logic signed [COORD_WIDTH-1:0] end_z,
	input  logic signed [COORD_WIDTH-1:0] query_x,
	input  logic signed [COORD_WIDTH-1:0] query_y,
	input  logic signed [COORD_WIDTH-1:0] query_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] near_x,
	output logic signed [COORD_WIDTH-1:0] near_y,
	output logic signed [COORD_WIDTH-1:0] near_z,
	output logic [1:0]                    which_case
);

	localparam int unsigned CW    = COORD_WIDTH;
	localparam int unsigned HW    = CW + 1;
	localparam int unsigned PW    = 2 * CW + 2;
	localparam int unsigned SW    = 2 * CW + 4;
	localparam int unsigned DW    = 2 * CW + 3;
	localparam int unsigned NW    = 3 * CW + 3;
	localparam int unsigned QB    = CW + 2;
	localparam int unsigned RW    = CW + 3;
	localparam int unsigned AX    = cpos_pkg::AXES;
	localparam int unsigned PASSW = 2 * AX * CW + AX + 2;
	localparam int unsigned FB    = FRAC_BITS;

	typedef logic signed [CW-1:0] crd_t;

	logic en;
	logic [AX-1:0][CW-1:0] in_a, in_b, in_p;

	logic                         vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	crd_t [AX-1:0]                a_s1, b_s1, a_s2, b_s2, a_s3, b_s3, a_s4, b_s4, a_s5, b_s5;
	logic [AX-1:0][HW-1:0]        d_s1, v_s1;
	logic [AX-1:0][PW-1:0]        vd_s2, dd_s2;
	logic [AX-1:0][HW-1:0]        dmag_s2, dmag_s3;
	logic [AX-1:0]                dneg_s2, dneg_s3, dneg_s4, dneg_s5;
	logic [SW-1:0]                dot_s3, len2_s3;
	logic [DW-1:0]                len2_s4;
	logic [1:0]                   case_s4, case_s5;
	logic [AX-1:0][PW-1:0]        plo_s4, phi_s4;
	logic [AX-1:0][NW-1:0]        num_s5;
	logic [DW-1:0]                den_s5;

	logic                         out_valid_q;
	crd_t [AX-1:0]                near_q;
	logic [1:0]                   case_q;

	assign in_a = {start_z, start_y, start_x};
	assign in_b = {end_z, end_y, end_x};
	assign in_p = {query_z, query_y, query_x};

	// The pipeline moves as one whenever the output register can take a word.
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// Valid bits of the arithmetic stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Stage 1: direction d = B - A and offset v = P - A.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < int'(AX); i++) begin
				a_s1[i] <= in_a[i];
				b_s1[i] <= in_b[i];
				d_s1[i] <= HW'($signed({in_b[i][CW-1], in_b[i]}) - $signed({in_a[i][CW-1], in_a[i]}));
				v_s1[i] <= HW'($signed({in_p[i][CW-1], in_p[i]}) - $signed({in_a[i][CW-1], in_a[i]}));
			end
		end
	end

	// Stage 2: per-axis products for the dot product and the squared length.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < int'(AX); i++) begin
				a_s2[i]    <= a_s1[i];
				b_s2[i]    <= b_s1[i];
				vd_s2[i]   <= PW'($signed(v_s1[i]) * $signed(d_s1[i]));
				dd_s2[i]   <= PW'($signed(d_s1[i]) * $signed(d_s1[i]));
				dneg_s2[i] <= d_s1[i][HW-1];
				dmag_s2[i] <= d_s1[i][HW-1] ? HW'(-d_s1[i]) : d_s1[i];
			end
		end
	end

	// Stage 3: sum the products.
	always_ff @(posedge clk) begin
		if (en) begin
			a_s3    <= a_s2;
			b_s3    <= b_s2;
			dneg_s3 <= dneg_s2;
			dmag_s3 <= dmag_s2;
			dot_s3  <= SW'($signed(vd_s2[0])) + SW'($signed(vd_s2[1])) + SW'($signed(vd_s2[2]));
			len2_s3 <= SW'(dd_s2[0]) + SW'(dd_s2[1]) + SW'(dd_s2[2]);
		end
	end

	// Stage 4: classify, and multiply |d| by the two halves of the dot product.
	always_ff @(posedge clk) begin
		if (en) begin
			a_s4    <= a_s3;
			b_s4    <= b_s3;
			dneg_s4 <= dneg_s3;
			len2_s4 <= len2_s3[DW-1:0];
			if ($signed(dot_s3) <= $signed(SW'(0))) begin
				case_s4 <= cpos_pkg::WC_START;
			end else if (dot_s3 >= len2_s3) begin
				case_s4 <= cpos_pkg::WC_END;
			end else begin
				case_s4 <= cpos_pkg::WC_INTERIOR;
			end
			for (int i = 0; i < int'(AX); i++) begin
				plo_s4[i] <= dmag_s3[i] * dot_s3[HW-1:0];
				phi_s4[i] <= dmag_s3[i] * dot_s3[2*HW-1:HW];
			end
		end
	end

	// Stage 5: rounding numerator 2*|d|*dot + len2 and denominator 2*len2.
	always_ff @(posedge clk) begin
		if (en) begin
			a_s5    <= a_s4;
			b_s5    <= b_s4;
			dneg_s5 <= dneg_s4;
			case_s5 <= case_s4;
			den_s5  <= {len2_s4[DW-2:0], 1'b0};
			for (int i = 0; i < int'(AX); i++) begin
				num_s5[i] <= ((NW'(phi_s4[i]) << HW) + NW'(plo_s4[i]) << 1) + NW'(len2_s4);
			end
		end
	end

	// Divider chain, one quotient bit per cell.
	logic                         c_vld  [0:QB];
	logic [AX-1:0][DW-1:0]        c_rem  [0:QB];
	logic [AX-1:0][QB-1:0]        c_sh   [0:QB];
	logic [DW-1:0]                c_den  [0:QB];
	logic [PASSW-1:0]             c_pass [0:QB];

	assign c_vld[0]  = vld_s5;
	assign c_den[0]  = den_s5;
	assign c_pass[0] = {case_s5, dneg_s5, b_s5, a_s5};
	always_comb begin
		for (int i = 0; i < int'(AX); i++) begin
			c_rem[0][i] = DW'(num_s5[i][NW-1:QB]);
			c_sh[0][i]  = num_s5[i][QB-1:0];
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_cell
		cpos_div_cell #(
			.DW    (DW),
			.QB    (QB),
			.PASSW (PASSW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_vld   (c_vld[k]),
			.in_rem   (c_rem[k]),
			.in_sh    (c_sh[k]),
			.in_den   (c_den[k]),
			.in_pass  (c_pass[k]),
			.out_vld  (c_vld[k+1]),
			.out_rem  (c_rem[k+1]),
			.out_sh   (c_sh[k+1]),
			.out_den  (c_den[k+1]),
			.out_pass (c_pass[k+1])
		);
	end

	// Output stage: apply the quotient to A, saturate, and choose the case.
	logic [AX-1:0][CW-1:0] t_a, t_b;
	logic [AX-1:0]         t_neg;
	logic [1:0]            t_case;
	crd_t [AX-1:0]         near_nxt;

	assign {t_case, t_neg, t_b, t_a} = c_pass[QB];

	always_comb begin
		logic signed [RW-1:0] r;
		for (int i = 0; i < int'(AX); i++) begin
			if (t_neg[i]) begin
				r = $signed(RW'($signed(t_a[i]))) - $signed(RW'(c_sh[QB][i]));
			end else begin
				r = $signed(RW'($signed(t_a[i]))) + $signed(RW'(c_sh[QB][i]));
			end
			unique case (t_case)
				cpos_pkg::WC_START: near_nxt[i] = t_a[i];
				cpos_pkg::WC_END:   near_nxt[i] = t_b[i];
				default: begin
					if (r[RW-1] && !(&r[RW-2:CW-1])) begin
						near_nxt[i] = {1'b1, {(CW-1){1'b0}}};
					end else if (!r[RW-1] && (|r[RW-2:CW-1])) begin
						near_nxt[i] = {1'b0, {(CW-1){1'b1}}};
					end else begin
						near_nxt[i] = r[CW-1:0];
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= c_vld[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			near_q <= near_nxt;
			case_q <= t_case;
		end
	end

	assign out_valid  = out_valid_q;
	assign near_x     = near_q[0];
	assign near_y     = near_q[1];
	assign near_z     = near_q[2];
	assign which_case = case_q;

	// The fraction width must fit the coordinate word.
	logic frac_ok;
	assign frac_ok = (FB < CW);

	`include "closest_point_on_segment_core_assert.svh"

	`CPOS_ASSERT_NOW(a_ready_follows_output, 1'b1, in_ready == (!out_valid_q || out_ready))
	`CPOS_ASSERT_NOW(a_case_code, out_valid_q, which_case != 2'd3 && frac_ok)
	`CPOS_ASSERT_NXT(a_stall_holds_chain, out_valid_q && !out_ready, c_vld[QB] == $past(c_vld[QB]) && vld_s1 == $past(vld_s1))
	`CPOS_ASSERT_NXT(a_word_reaches_output, en && c_vld[QB], out_valid_q)

endmodule

/* tb/tb_closest_point_on_segment_core.sv */
// Testbench for closest_point_on_segment_core: directed and random segment queries
// checked against an exact integer predictor held in a small scoreboard class.
// Depends on cpos_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_closest_point_on_segment_core;

	localparam int CW = 32;
	localparam int LATENCY = CW + 8;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int N_RANDOM = 1330;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		cpos_pkg::case_t wc;
	} near_word_t;

	// Scoreboard: predicts the nearest point of each accepted word and checks results.
	class near_point_board;
		near_word_t pending[$];
		int errors;
		int checked;
		int n_case[3];

		function void note_word(coord_t a[3], coord_t b[3], coord_t p[3]);
			logic signed [CW:0] d[3];
			logic signed [CW:0] v[3];
			logic signed [127:0] dot;
			logic signed [127:0] len2;
			logic [127:0] num;
			logic [127:0] q;
			logic signed [127:0] r;
			logic [CW:0] dmag;
			coord_t res[3];
			near_word_t w;
			dot = 0;
			len2 = 0;
			for (int i = 0; i < 3; i++) begin
				d[i] = {b[i][CW-1], b[i]} - {a[i][CW-1], a[i]};
				v[i] = {p[i][CW-1], p[i]} - {a[i][CW-1], a[i]};
				dot += 128'(d[i]) * 128'(v[i]);
				len2 += 128'(d[i]) * 128'(d[i]);
			end
			if (dot <= 0) begin
				w = '{a[0], a[1], a[2], cpos_pkg::WC_START};
			end else if (dot >= len2) begin
				w = '{b[0], b[1], b[2], cpos_pkg::WC_END};
			end else begin
				// Interior: round |d| * dot / len2 to nearest, halves up in magnitude.
				for (int i = 0; i < 3; i++) begin
					dmag = d[i] < 0 ? -d[i] : d[i];
					num = 2 * (128'(dmag) * dot) + len2;
					q = num / (2 * len2);
					r = d[i] < 0 ? 128'(a[i]) - $signed(q) : 128'(a[i]) + $signed(q);
					if (r > 128'sd2147483647) r = 128'sd2147483647;
					if (r < -128'sd2147483648) r = -128'sd2147483648;
					res[i] = r[CW-1:0];
				end
				w = '{res[0], res[1], res[2], cpos_pkg::WC_INTERIOR};
			end
			pending.push_back(w);
		endfunction

		function void check_word(coord_t x, coord_t y, coord_t z, logic [1:0] wc);
			near_word_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result word x=%0d y=%0d z=%0d case=%0d",
					$time, x, y, z, wc);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (e.wc <= cpos_pkg::WC_END) n_case[e.wc]++;
			if (x !== e.x) begin
				$display("%0t: near_x expected %0d actual %0d", $time, e.x, x);
				errors++;
			end
			if (y !== e.y) begin
				$display("%0t: near_y expected %0d actual %0d", $time, e.y, y);
				errors++;
			end
			if (z !== e.z) begin
				$display("%0t: near_z expected %0d actual %0d", $time, e.z, z);
				errors++;
			end
			if (wc !== e.wc) begin
				$display("%0t: which_case expected %0d actual %0d", $time, e.wc, wc);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	coord_t start_x, start_y, start_z, end_x, end_y, end_z, query_x, query_y, query_z;
	logic out_valid;
	logic out_ready;
	coord_t near_x, near_y, near_z;
	logic [1:0] which_case;

	near_point_board board;
	int idle_cycles;
	bit sending_done;

	closest_point_on_segment_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.start_x(start_x), .start_y(start_y), .start_z(start_z),
		.end_x(end_x), .end_y(end_y), .end_z(end_z),
		.query_x(query_x), .query_y(query_y), .query_z(query_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.near_x(near_x), .near_y(near_y), .near_z(near_z),
		.which_case(which_case)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic coord_t rand_coord(int mode);
		case (mode)
			0: return coord_t'($urandom());
			1: return coord_t'($signed($urandom_range(0, 4096)) - 2048);
			default: return coord_t'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
		endcase
	endfunction

	// Drive one word and hold it until accepted; valid drops only during a gap.
	task automatic send_word(coord_t a[3], coord_t b[3], coord_t p[3]);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		start_x <= a[0]; start_y <= a[1]; start_z <= a[2];
		end_x <= b[0]; end_y <= b[1]; end_z <= b[2];
		query_x <= p[0]; query_y <= p[1]; query_z <= p[2];
		do @(posedge clk); while (!in_ready);
		board.note_word(a, b, p);
	endtask

	task automatic send_random();
		coord_t a[3], b[3], p[3];
		int mode;
		mode = $urandom_range(0, 2);
		for (int i = 0; i < 3; i++) begin
			a[i] = rand_coord(mode);
			b[i] = ($urandom_range(0, 19) == 0) ? a[i] : rand_coord(mode);
			p[i] = rand_coord(mode);
		end
		// Now and then put the query at an endpoint or the segment's midpoint.
		case ($urandom_range(0, 9))
			0: p = a;
			1: p = b;
			2: for (int i = 0; i < 3; i++) p[i] = coord_t'((64'(a[i]) + 64'(b[i])) >>> 1);
			default: ;
		endcase
		send_word(a, b, p);
	endtask

	task automatic send_directed();
		coord_t mx, mn;
		coord_t a[3], b[3], p[3];
		mx = 32'sh7fff_ffff;
		mn = 32'sh8000_0000;
		// Degenerate segment.
		a = '{32'sd65536, -32'sd7, 32'sd3}; b = a; p = '{32'sd1, 32'sd2, 32'sd3};
		send_word(a, b, p);
		// Before the start, past the end, at the end, interior.
		a = '{32'sd0, 32'sd0, 32'sd0}; b = '{32'sd1000, 32'sd0, 32'sd0};
		p = '{-32'sd5, 32'sd9, 32'sd0}; send_word(a, b, p);
		p = '{32'sd2000, 32'sd9, 32'sd0}; send_word(a, b, p);
		p = '{32'sd1000, 32'sd9, 32'sd0}; send_word(a, b, p);
		p = '{32'sd333, -32'sd9, 32'sd4}; send_word(a, b, p);
		// Rounding on a half: each moving axis lands exactly halfway between steps.
		a = '{32'sd0, 32'sd0, 32'sd0}; b = '{32'sd2, 32'sd2, 32'sd0};
		p = '{32'sd1, 32'sd0, 32'sd0}; send_word(a, b, p);
		b = '{-32'sd2, -32'sd2, 32'sd0}; p = '{-32'sd1, 32'sd0, 32'sd0}; send_word(a, b, p);
		// Full-range extremes.
		a = '{mn, mn, mn}; b = '{mx, mx, mx}; p = '{32'sd0, 32'sd0, 32'sd0}; send_word(a, b, p);
		p = '{mx, mn, mx}; send_word(a, b, p);
		p = '{mn, mn, mn}; send_word(a, b, p);
		a = '{mx, mn, mx}; b = '{mn, mx, mn}; p = '{32'sd5, -32'sd3, 32'sd77}; send_word(a, b, p);
		a = '{mx, mx, mx}; b = '{mx, mx, mn}; p = '{mn, mn, mn}; send_word(a, b, p);
		a = '{32'sd0, 32'sd0, mn}; b = '{32'sd0, 32'sd0, mx}; p = '{mx, mn, 32'sd1};
		send_word(a, b, p);
		a = '{-32'sd1, 32'sd0, 32'sd0}; b = '{32'sd0, -32'sd1, 32'sd0}; p = '{mx, mx, mx};
		send_word(a, b, p);
	endtask

	// Receiver: random stalls, checks each accepted word.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				board.check_word(near_x, near_y, near_z, which_case);
			out_ready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
		end
	end

	// Watchdog: cycles in a row with no word moving on either side.
	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired with %0d words outstanding",
					$time, board.pending.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		{start_x, start_y, start_z, end_x, end_y, end_z} = '0;
		{query_x, query_y, query_z} = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_directed();
		repeat (N_RANDOM) send_random();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("Checked %0d words: %0d interior, %0d clamped to start, %0d clamped to end.",
			board.checked, board.n_case[cpos_pkg::WC_INTERIOR],
			board.n_case[cpos_pkg::WC_START], board.n_case[cpos_pkg::WC_END]);
		if (board.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
